// ===== hdl/ffe_pkg.sv =====
// Shared types, constants and root table for the form factor pipeline.
`timescale 1ns / 1ps
package ffe_pkg;

    localparam int QW     = 16;
    localparam int FFW    = 20;
    localparam int AMPW   = 18;
    localparam int RATEW  = 23;
    localparam int S2W    = 25;
    localparam int FRACB  = 20;
    localparam int EW     = 44;
    localparam int EHALF  = 22;
    localparam int MW     = 31;
    localparam int NW     = 10;
    localparam int TW     = 30;
    localparam int YW     = 32;
    localparam int NLANE  = 3;
    localparam int ADDRW  = 5;
    localparam int DATAW  = 32;

    localparam logic [S2W-1:0]       S2_SCALE  = 25'd27198198;
    localparam logic signed [TW-1:0] LOG2E_Q28 = 30'sd387270501;
    localparam logic [EW-1:0]        E_CLIP    = {EW{1'b1}};
    localparam logic signed [NW-1:0] N_CLIP    = 10'sd20;
    localparam logic signed [NW-1:0] N_UNITY   = 10'sd6;
    localparam logic signed [FFW-1:0] OUT_MAX  = 20'sd524287;
    localparam logic signed [FFW-1:0] OUT_MIN  = -20'sd524288;

    // register indexes
    localparam logic [2:0] REG_AMP_ONE    = 3'd0;
    localparam logic [2:0] REG_RATE_ONE   = 3'd1;
    localparam logic [2:0] REG_AMP_TWO    = 3'd2;
    localparam logic [2:0] REG_RATE_TWO   = 3'd3;
    localparam logic [2:0] REG_AMP_THREE  = 3'd4;
    localparam logic [2:0] REG_RATE_THREE = 3'd5;
    localparam logic [2:0] REG_OFFSET     = 3'd6;

    typedef struct packed {
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
    } t_q_in;

    typedef struct packed {
        logic signed [FFW-1:0] form_factor;
        logic                  saturated;
    } t_ff_out;

    typedef logic [FRACB-1:0][MW-1:0] t_roots;

    // Integer square root, evaluated at elaboration only.
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = x;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Root factors 2^(2^-k) in Q.30, k = 1 first.
    function automatic t_roots build_roots();
        t_roots      t;
        logic [63:0] r;
        r = isqrt64(64'd1 << 61);
        t[0] = r[MW-1:0];
        for (int k = 1; k < FRACB; k++) begin
            r = isqrt64(r << 30);
            t[k] = r[MW-1:0];
        end
        return t;
    endfunction

    localparam t_roots ROOTS = build_roots();

endpackage

// ===== hdl/ffe_sq.sv =====
// Squared magnitude of q and its scaling to s2.
`timescale 1ns / 1ps
module ffe_sq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  ffe_pkg::t_q_in               i_q,
    output logic                         o_valid,
    output logic [ffe_pkg::S2W-1:0]      o_s2
);

    logic [3:0]  r_v;
    logic [31:0] r_sqx, r_sqy, r_sqz;
    logic [31:0] r_sum;
    logic [56:0] r_prod;
    logic [ffe_pkg::S2W-1:0] r_s2;

    logic [31:0] n_sqx, n_sqy, n_sqz;
    logic [31:0] n_sum;
    logic [56:0] n_prod;
    logic [57:0] n_rnd;

    // square, add, scale, round
    always_comb begin
        n_sqx  = $unsigned(32'(i_q.qx) * 32'(i_q.qx));
        n_sqy  = $unsigned(32'(i_q.qy) * 32'(i_q.qy));
        n_sqz  = $unsigned(32'(i_q.qz) * 32'(i_q.qz));
        n_sum  = r_sqx + r_sqy + r_sqz;
        n_prod = 57'(r_sum) * 57'(ffe_pkg::S2_SCALE);
        n_rnd  = 58'(r_prod) + (58'd1 << 31);
    end

    // hold valids under stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // advance data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sqx  <= n_sqx;
            r_sqy  <= n_sqy;
            r_sqz  <= n_sqz;
            r_sum  <= n_sum;
            r_prod <= n_prod;
            r_s2   <= n_rnd[56:32];
        end
    end

    assign o_valid = r_v[3];
    assign o_s2    = r_s2;

endmodule

// ===== hdl/ffe_exp.sv =====
// One exponential lane: exp(-rate*s2) by base-2 split and root products.
`timescale 1ns / 1ps
module ffe_exp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [ffe_pkg::S2W-1:0]             i_s2,
    input  logic signed [ffe_pkg::RATEW-1:0]    i_rate,
    output logic                                o_valid,
    output logic [ffe_pkg::EW-1:0]              o_e,
    output logic                                o_clip
);

    localparam int NS = ffe_pkg::FRACB + 1;

    logic                               r_v1, r_v2, r_v3;
    logic signed [47:0]                 r_p;
    logic signed [ffe_pkg::YW-1:0]      r_y;
    logic signed [61:0]                 r_q;

    logic [ffe_pkg::MW-1:0]             r_m [NS];
    logic [ffe_pkg::FRACB-1:0]          r_f [NS];
    logic signed [ffe_pkg::NW-1:0]      r_n [NS];
    logic                               r_c [NS];
    logic                               r_vs [NS];

    logic                               r_ve;
    logic [ffe_pkg::EW-1:0]             r_e;
    logic                               r_ce;

    logic signed [47:0]                 n_p;
    logic signed [48:0]                 n_yt;
    logic signed [ffe_pkg::YW-1:0]      n_y;
    logic signed [61:0]                 n_q;
    logic signed [62:0]                 n_qr;
    logic [ffe_pkg::TW-1:0]             n_t;
    logic [61:0]                        n_prod [ffe_pkg::FRACB];
    logic [ffe_pkg::MW-1:0]             n_m [ffe_pkg::FRACB];
    logic [3:0]                         n_shl;
    logic [10:0]                        n_sa;
    logic [ffe_pkg::EW-1:0]             n_e;

    // exponent: y = -rate*s2, t = y*log2(e), split into n and f
    always_comb begin
        n_p  = 48'(i_rate) * 48'($signed({1'b0, i_s2}));
        n_yt = -$signed({r_p[47], r_p}) + 49'sd32768;
        n_y  = ffe_pkg::YW'(n_yt >>> 16);
        n_q  = 62'(r_y) * 62'(ffe_pkg::LOG2E_Q28);
        n_qr = 63'(r_q) + (63'sd1 <<< 31);
        n_t  = ffe_pkg::TW'(n_qr >>> 32);
    end

    // fraction: multiply in one root factor per stage
    always_comb begin
        for (int k = 0; k < ffe_pkg::FRACB; k++) begin
            n_prod[k] = 62'(r_m[k]) * 62'(ffe_pkg::ROOTS[k]);
            n_m[k]    = r_f[k][ffe_pkg::FRACB-1-k] ? n_prod[k][60:30] : r_m[k];
        end
    end

    // integer part: shift mantissa into Q.24, clip on overflow
    always_comb begin
        n_shl = 4'(r_n[NS-1] - ffe_pkg::N_UNITY);
        n_sa  = 11'(11'sd6 - 11'(r_n[NS-1]));
        if (r_c[NS-1]) begin
            n_e = ffe_pkg::E_CLIP;
        end else if (r_n[NS-1] >= ffe_pkg::N_UNITY) begin
            n_e = ffe_pkg::EW'(r_m[NS-1]) << n_shl;
        end else if (n_sa >= 11'd31) begin
            n_e = '0;
        end else begin
            n_e = ffe_pkg::EW'(r_m[NS-1] >> n_sa[4:0]);
        end
    end

    // hold valids under stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ve <= 1'b0;
            for (int k = 0; k < NS; k++) begin
                r_vs[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_vs[0] <= r_v3;
            for (int k = 1; k < NS; k++) begin
                r_vs[k] <= r_vs[k-1];
            end
            r_ve <= r_vs[NS-1];
        end
    end

    // advance data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p    <= n_p;
            r_y    <= n_y;
            r_q    <= n_q;
            r_m[0] <= {1'b1, 30'b0};
            r_f[0] <= n_t[ffe_pkg::FRACB-1:0];
            r_n[0] <= $signed(n_t[ffe_pkg::TW-1:ffe_pkg::FRACB]);
            r_c[0] <= $signed(n_t[ffe_pkg::TW-1:ffe_pkg::FRACB]) >= ffe_pkg::N_CLIP;
            for (int k = 1; k < NS; k++) begin
                r_m[k] <= n_m[k-1];
                r_f[k] <= r_f[k-1];
                r_n[k] <= r_n[k-1];
                r_c[k] <= r_c[k-1];
            end
            r_e  <= n_e;
            r_ce <= r_c[NS-1];
        end
    end

    assign o_valid = r_ve;
    assign o_e     = r_e;
    assign o_clip  = r_ce;

endmodule

// ===== hdl/ffe_sum.sv =====
// Amplitude products, sum with offset, rounding and saturation.
`timescale 1ns / 1ps
module ffe_sum (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_en,
    input  logic                                          i_valid,
    input  logic [ffe_pkg::NLANE-1:0][ffe_pkg::EW-1:0]    i_e,
    input  logic                                          i_clip,
    input  logic [ffe_pkg::NLANE-1:0][ffe_pkg::AMPW-1:0]  i_amp,
    input  logic signed [ffe_pkg::AMPW-1:0]               i_off,
    output logic                                          o_valid,
    output ffe_pkg::t_ff_out                              o_data
);

    logic [3:0]         r_v;
    logic [2:0]         r_c;
    logic signed [40:0] r_ph [ffe_pkg::NLANE];
    logic signed [40:0] r_pl [ffe_pkg::NLANE];
    logic signed [62:0] r_t  [ffe_pkg::NLANE];
    logic signed [64:0] r_acc;
    ffe_pkg::t_ff_out   r_out;

    logic signed [40:0] n_ph [ffe_pkg::NLANE];
    logic signed [40:0] n_pl [ffe_pkg::NLANE];
    logic signed [62:0] n_t  [ffe_pkg::NLANE];
    logic signed [64:0] n_acc;
    logic signed [64:0] n_rnd;
    logic signed [40:0] n_r;
    ffe_pkg::t_ff_out   n_out;

    // split each 44-bit exponential into two halves for the products
    always_comb begin
        for (int k = 0; k < ffe_pkg::NLANE; k++) begin
            n_ph[k] = 41'($signed(i_amp[k]))
                    * 41'($signed({1'b0, i_e[k][ffe_pkg::EW-1:ffe_pkg::EHALF]}));
            n_pl[k] = 41'($signed(i_amp[k]))
                    * 41'($signed({1'b0, i_e[k][ffe_pkg::EHALF-1:0]}));
            n_t[k]  = (63'(r_ph[k]) <<< ffe_pkg::EHALF) + 63'(r_pl[k]);
        end
        n_acc = (65'(i_off) <<< 24) + 65'(r_t[0]) + 65'(r_t[1]) + 65'(r_t[2]);
        n_rnd = r_acc + (65'sd1 <<< 23);
        n_r   = 41'(n_rnd >>> 24);
        if (n_r > 41'(ffe_pkg::OUT_MAX)) begin
            n_out.form_factor = ffe_pkg::OUT_MAX;
            n_out.saturated   = 1'b1;
        end else if (n_r < 41'(ffe_pkg::OUT_MIN)) begin
            n_out.form_factor = ffe_pkg::OUT_MIN;
            n_out.saturated   = 1'b1;
        end else begin
            n_out.form_factor = ffe_pkg::FFW'(n_r);
            n_out.saturated   = r_c[2];
        end
    end

    // hold valids under stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // advance data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= {r_c[1:0], i_clip};
            for (int k = 0; k < ffe_pkg::NLANE; k++) begin
                r_ph[k] <= n_ph[k];
                r_pl[k] <= n_pl[k];
                r_t[k]  <= n_t[k];
            end
            r_acc <= n_acc;
            r_out <= n_out;
        end
    end

    assign o_valid = r_v[3];
    assign o_data  = r_out;

endmodule

// ===== hdl/magnetic_form_factor_eval.sv =====
// Top level: register file, pipeline stages and stall control.
`timescale 1ns / 1ps
// Evaluates the j0 magnetic form factor A*exp(-a*s2) + B*exp(-b*s2) + C*exp(-c*s2) + D
// for one Q4.12 scattering vector per cycle unless stalled, with s2 = |q|^2/(16 pi^2).
// The pipeline passes each vector through 4 stages for s2, 25 per exponential lane
// (one stage for each of the 20 root-factor multiplies) and 4 for products, sum and
// saturation; the three exponentials run in parallel lanes. A stalled output freezes
// the whole pipeline. Coefficients sit at APB byte addresses 0,4,..,24 in the order
// A, a, B, b, C, c, D and must be written while no vector is in flight. saturated
// flags a clipped exponential or a clipped result.
module magnetic_form_factor_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  ffe_pkg::t_q_in                i_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output ffe_pkg::t_ff_out              o_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffe_pkg::ADDRW-1:0]     paddr,
    input  logic [ffe_pkg::DATAW-1:0]     pwdata,
    output logic [ffe_pkg::DATAW-1:0]     prdata,
    output logic                          pready
);

    logic [ffe_pkg::NLANE-1:0][ffe_pkg::AMPW-1:0]  r_amp;
    logic [ffe_pkg::NLANE-1:0][ffe_pkg::RATEW-1:0] r_rate;
    logic signed [ffe_pkg::AMPW-1:0]               r_off;

    logic                                          w_en;
    logic                                          w_sq_v;
    logic [ffe_pkg::S2W-1:0]                       w_s2;
    logic [ffe_pkg::NLANE-1:0]                     w_lane_v;
    logic [ffe_pkg::NLANE-1:0]                     w_lane_c;
    logic [ffe_pkg::NLANE-1:0][ffe_pkg::EW-1:0]    w_e;
    logic [2:0]                                    w_idx;
    logic                                          w_wr;

    // freeze all pipeline stages while the output transfer is held
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // configuration writes
    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp  <= '0;
            r_rate <= '0;
            r_off  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                ffe_pkg::REG_AMP_ONE:    r_amp[0]  <= pwdata[ffe_pkg::AMPW-1:0];
                ffe_pkg::REG_RATE_ONE:   r_rate[0] <= pwdata[ffe_pkg::RATEW-1:0];
                ffe_pkg::REG_AMP_TWO:    r_amp[1]  <= pwdata[ffe_pkg::AMPW-1:0];
                ffe_pkg::REG_RATE_TWO:   r_rate[1] <= pwdata[ffe_pkg::RATEW-1:0];
                ffe_pkg::REG_AMP_THREE:  r_amp[2]  <= pwdata[ffe_pkg::AMPW-1:0];
                ffe_pkg::REG_RATE_THREE: r_rate[2] <= pwdata[ffe_pkg::RATEW-1:0];
                ffe_pkg::REG_OFFSET:     r_off     <= pwdata[ffe_pkg::AMPW-1:0];
                default: ;
            endcase
        end
    end

    // register readback, sign extended
    always_comb begin
        unique case (w_idx)
            ffe_pkg::REG_AMP_ONE:    prdata = 32'($signed(r_amp[0]));
            ffe_pkg::REG_RATE_ONE:   prdata = 32'($signed(r_rate[0]));
            ffe_pkg::REG_AMP_TWO:    prdata = 32'($signed(r_amp[1]));
            ffe_pkg::REG_RATE_TWO:   prdata = 32'($signed(r_rate[1]));
            ffe_pkg::REG_AMP_THREE:  prdata = 32'($signed(r_amp[2]));
            ffe_pkg::REG_RATE_THREE: prdata = 32'($signed(r_rate[2]));
            ffe_pkg::REG_OFFSET:     prdata = 32'(r_off);
            default:                 prdata = '0;
        endcase
    end

    ffe_sq u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_q     (i_data),
        .o_valid (w_sq_v),
        .o_s2    (w_s2)
    );

    for (genvar g = 0; g < ffe_pkg::NLANE; g++) begin : g_lane
        ffe_exp u_exp (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_v),
            .i_s2    (w_s2),
            .i_rate  ($signed(r_rate[g])),
            .o_valid (w_lane_v[g]),
            .o_e     (w_e[g]),
            .o_clip  (w_lane_c[g])
        );
    end

    ffe_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_lane_v[0]),
        .i_e     (w_e),
        .i_clip  (|w_lane_c),
        .i_amp   (r_amp),
        .i_off   (r_off),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    // lanes run in lockstep
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_lane_v[0] == w_lane_v[1]) && (w_lane_v[1] == w_lane_v[2]))
        else $error("exponential lanes out of step");

    // nothing leaves right after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // input stall only when a result is held at the output
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

endmodule

// ===== verif/magnetic_form_factor_eval_tb.sv =====
// Testbench for the form factor pipeline: directed and random vectors, scoreboard check.
`timescale 1ns / 1ps
module magnetic_form_factor_eval_tb;
    import ffe_pkg::*;

    localparam int LATENCY = 40;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    t_q_in         i_data;
    logic          o_valid;
    logic          i_stall;
    t_ff_out       o_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [ADDRW-1:0] paddr;
    logic [DATAW-1:0] pwdata;
    logic [DATAW-1:0] prdata;
    logic          pready;

    magnetic_form_factor_eval dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Coefficient shadow, root factors, vectors to send and form factors awaited
    longint  coef [7];
    longint  root_q30 [FRACB];
    t_q_in   vectors_to_send [$];
    t_ff_out form_factors_due [$];
    int      errors;
    bit      calm;
    int      send_gap;
    int      recv_gap;

    initial begin
        i_clk = 1'b0;
    end
    always #4 i_clk = ~i_clk;

    // Integer square root by bit pairs
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned b;
        rem = x;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // exp(-rate*s2) in Q.24, flags clipping of large exponentials
    function automatic longint gauss_q24(input longint rate, input longint s2,
                                         inout bit clip);
        longint          y;
        longint          t;
        longint          n;
        longint unsigned frac;
        longint unsigned m;
        y = round_shift(-(rate * s2), 16);
        t = round_shift(y * 64'sd387270501, 32);
        frac = t & 64'hF_FFFF;
        n = t >>> FRACB;
        m = 64'd1 << 30;
        if (n >= 20) begin
            clip = 1'b1;
            return (64'sd1 <<< 44) - 1;
        end
        for (int k = 0; k < FRACB; k++)
            if (frac[FRACB-1-k])
                m = (m * longint'(root_q30[k])) >> 30;
        if (n >= 6)
            return longint'(m << (n - 6));
        if (6 - n > 40)
            return 0;
        return longint'(m >> (6 - n));
    endfunction

    function automatic t_ff_out predict_form_factor(input t_q_in q);
        longint          x, y, z;
        longint unsigned sq_sum;
        longint          s2;
        longint          acc;
        longint          r;
        bit              clip;
        t_ff_out         res;
        x = q.qx;
        y = q.qy;
        z = q.qz;
        sq_sum = x * x + y * y + z * z;
        s2 = longint'((sq_sum * 64'd27198198 + (64'd1 << 31)) >> 32);
        clip = 1'b0;
        acc = coef[REG_OFFSET] * (64'sd1 <<< 24);
        for (int k = 0; k < NLANE; k++)
            acc += coef[2 * k] * gauss_q24(coef[2 * k + 1], s2, clip);
        r = round_shift(acc, 24);
        if (r > 524287) begin
            r = 524287;
            clip = 1'b1;
        end else if (r < -524288) begin
            r = -524288;
            clip = 1'b1;
        end
        res.form_factor = r[FFW-1:0];
        res.saturated   = clip;
        return res;
    endfunction

    // Driver: present vectors, record the expected result at each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            i_data   <= '0;
            send_gap <= 0;
        end else begin
            if (i_valid && !o_stall)
                form_factors_due.push_back(predict_form_factor(i_data));
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (vectors_to_send.size() > 0) begin
                    i_valid <= 1'b1;
                    i_data  <= vectors_to_send.pop_front();
                    if (!calm && $urandom_range(0, 19) == 0)
                        send_gap <= $urandom_range(1, 15);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_ff_out exp_ff;
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (form_factors_due.size() == 0) begin
                    $error("unexpected result form_factor=%0d", $signed(o_data.form_factor));
                    errors++;
                end else begin
                    exp_ff = form_factors_due.pop_front();
                    if (o_data.form_factor !== exp_ff.form_factor) begin
                        $error("form_factor expected %0d actual %0d",
                               $signed(exp_ff.form_factor), $signed(o_data.form_factor));
                        errors++;
                    end
                    if (o_data.saturated !== exp_ff.saturated) begin
                        $error("saturated expected %0b actual %0b",
                               exp_ff.saturated, o_data.saturated);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall  <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (!calm && $urandom_range(0, 11) == 0)
                    recv_gap <= $urandom_range(1, 15);
            end
        end
    end

    task automatic reg_write(input int idx, input logic [31:0] raw);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDRW'(idx * 4);
        pwdata  <= raw;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < 7) begin
            if (idx == REG_RATE_ONE || idx == REG_RATE_TWO || idx == REG_RATE_THREE)
                coef[idx] = longint'($signed(raw[RATEW-1:0]));
            else
                coef[idx] = longint'($signed(raw[AMPW-1:0]));
        end
    endtask

    // Hold until the pipeline is empty, then let it drain
    task automatic drain();
        while (vectors_to_send.size() > 0 || i_valid || form_factors_due.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic load_coefs(input int a1, input int r1, input int a2, input int r2,
                              input int a3, input int r3, input int d);
        drain();
        reg_write(REG_AMP_ONE, a1);
        reg_write(REG_RATE_ONE, r1);
        reg_write(REG_AMP_TWO, a2);
        reg_write(REG_RATE_TWO, r2);
        reg_write(REG_AMP_THREE, a3);
        reg_write(REG_RATE_THREE, r3);
        reg_write(REG_OFFSET, d);
    endtask

    function automatic int rand_amp();
        return int'($urandom_range(0, 262143)) - 131072;
    endfunction

    function automatic int rand_rate();
        if ($urandom_range(0, 3) == 0)
            return int'($urandom_range(0, 8388607)) - 4194304;
        if ($urandom_range(0, 3) == 0)
            return -int'($urandom_range(0, 4 << 16));
        return int'($urandom_range(0, 60 << 16));
    endfunction

    function automatic t_q_in rand_vector();
        t_q_in q;
        if ($urandom_range(0, 9) < 7) begin
            q.qx = QW'(int'($urandom_range(0, 16383)) - 8192);
            q.qy = QW'(int'($urandom_range(0, 16383)) - 8192);
            q.qz = QW'(int'($urandom_range(0, 16383)) - 8192);
        end else begin
            q = t_q_in'(48'({$urandom, $urandom}));
        end
        return q;
    endfunction

    task automatic push_vec(input int x, input int y, input int z);
        t_q_in q;
        q.qx = QW'(x);
        q.qy = QW'(y);
        q.qz = QW'(z);
        vectors_to_send.push_back(q);
    endtask

    task automatic directed_vectors();
        push_vec(0, 0, 0);
        push_vec(32767, 32767, 32767);
        push_vec(-32768, -32768, -32768);
        push_vec(-32768, 0, 0);
        push_vec(0, 32767, 0);
        push_vec(0, 0, -32768);
        push_vec(4096, 0, 0);
        push_vec(1, -1, 1);
        push_vec(16'h5555, 16'hAAAA, 16'h5555);
        push_vec(16'hAAAA, 16'h5555, 16'hAAAA);
        push_vec(2048, 2048, 2048);
        push_vec(-8192, 8192, 0);
    endtask

    task automatic random_vectors(input int count);
        repeat (count) vectors_to_send.push_back(rand_vector());
    endtask

    initial begin
        errors  = 0;
        calm    = 1'b0;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_valid = 1'b0;
        i_data  = '0;
        i_stall = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        for (int i = 0; i < 7; i++) coef[i] = 0;
        root_q30[0] = int_sqrt(64'd1 << 61);
        for (int k = 1; k < FRACB; k++)
            root_q30[k] = int_sqrt(longint'(root_q30[k - 1]) << 30);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients: everything evaluates to zero
        push_vec(0, 0, 0);
        push_vec(32767, -32768, 1);
        random_vectors(10);

        // Typical ion: moderate positive rates, mixed amplitudes
        load_coefs(23134, 2334080, 24117, 768000, -9830, 169000, 1966);
        reg_write(7, 32'hDEAD_BEEF);
        directed_vectors();
        random_vectors(120);

        // Extremes: largest and most negative amplitudes and rates; most negative rates force clipping
        load_coefs(131071, -4194304, 131071, -4194304, 131071, -4194304, 131071);
        directed_vectors();
        random_vectors(40);
        load_coefs(-131072, 4194303, -131072, 0, -131072, -65536, -131072);
        directed_vectors();
        random_vectors(60);
        load_coefs(-131072, -4194304, 131071, 4194303, 0, -4194304, 0);
        random_vectors(40);

        // Random settings
        for (int p = 0; p < 5; p++) begin
            load_coefs(rand_amp(), rand_rate(), rand_amp(), rand_rate(),
                       rand_amp(), rand_rate(), rand_amp());
            random_vectors(90);
        end

        // Closing stretch with no idling on either side
        calm = 1'b1;
        load_coefs(rand_amp(), int'($urandom_range(0, 20 << 16)), rand_amp(),
                   int'($urandom_range(0, 20 << 16)), rand_amp(),
                   int'($urandom_range(0, 20 << 16)), rand_amp());
        random_vectors(80);

        drain();
        if (errors == 0)
            $display("PASS magnetic_form_factor_eval");
        else
            $display("FAIL magnetic_form_factor_eval");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL magnetic_form_factor_eval");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/ffe_pkg.sv
hdl/ffe_sq.sv
hdl/ffe_exp.sv
hdl/ffe_sum.sv
hdl/magnetic_form_factor_eval.sv
verif/magnetic_form_factor_eval_tb.sv
